FILE: hw/rtl/lru_page_replacement_defines.svh
// Assertion macros used by the LRU page replacement RTL.
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define LRUP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define LRUP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/lrup_pkg.sv
// Shared constants and command codes for the LRU page replacement block.
package lrup_pkg;

    localparam int FRAMES_DEF    = 64;
    localparam int PAGE_BITS_DEF = 20;

    localparam int CNT_BITS = 32;
    localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

    localparam logic CMD_REF     = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

endpackage

FILE: hw/rtl/lrup_frame_mem.sv
// Frame page and recency rank memories with one registered read port.
module lrup_frame_mem #(
    parameter int FRAMES    = lrup_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF,
    localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
    input  logic                 aclk,
    input  logic                 rd_en,
    input  logic [IDX_W-1:0]     rd_addr,
    output logic [PAGE_BITS-1:0] rd_page,
    output logic [IDX_W-1:0]     rd_rank,
    input  logic [IDX_W-1:0]     wr_addr,
    input  logic                 pg_we,
    input  logic [PAGE_BITS-1:0] pg_wdata,
    input  logic                 rk_we,
    input  logic [IDX_W-1:0]     rk_wdata
);

    logic [PAGE_BITS-1:0] page_mem [FRAMES];
    logic [IDX_W-1:0]     rank_mem [FRAMES];
    logic [PAGE_BITS-1:0] rd_page_reg;
    logic [IDX_W-1:0]     rd_rank_reg;

    always_ff @(posedge aclk) begin
        if (pg_we) begin
            page_mem[wr_addr] <= pg_wdata;
        end
        if (rk_we) begin
            rank_mem[wr_addr] <= rk_wdata;
        end
        if (rd_en) begin
            rd_page_reg <= page_mem[rd_addr];
            rd_rank_reg <= rank_mem[rd_addr];
        end
    end

    assign rd_page = rd_page_reg;
    assign rd_rank = rd_rank_reg;

endmodule

FILE: hw/rtl/lru_page_replacement.sv
// LRU page replacement: a reference passes the scan, decide, update and finish states.
// The scan reads one active frame per cycle from the frame memory, then a rank sweep
// reads one frame per cycle over all FRAMES entries and rewrites the ranks that change.
// One item is in work at once; a restart request goes straight to the finish state.
// Reset (aresetn low, synchronous) clears frame valid bits, both counters and the result
// valid flag, and sets frames_in_use to FRAMES; the memories need no clearing pass.
`include "lru_page_replacement_defines.svh"

module lru_page_replacement #(
    parameter int FRAMES    = lrup_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrup_pkg::PAGE_BITS_DEF,
    localparam int IDX_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    localparam int CNT_W    = $clog2(FRAMES + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [CNT_W-1:0]              cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_cmd,
    input  logic [PAGE_BITS-1:0]          s_page_number,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_hit,
    output logic [IDX_W-1:0]              m_frame_index,
    output logic                          m_evicted_valid,
    output logic [PAGE_BITS-1:0]          m_evicted_page,
    output logic [lrup_pkg::CNT_BITS-1:0] m_fault_count,
    output logic [lrup_pkg::CNT_BITS-1:0] m_reference_count
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_FINISH = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]              fiu_reg, fiu_next;
    logic [CNT_W-1:0]              act_reg, act_next;
    logic [PAGE_BITS-1:0]          page_reg, page_next;
    logic [CNT_W-1:0]              issue_cnt_reg, issue_cnt_next;
    logic                          pend_reg, pend_next;
    logic                          pend_last_reg, pend_last_next;
    logic [IDX_W-1:0]              pend_idx_reg, pend_idx_next;
    logic                          hit_found_reg, hit_found_next;
    logic [IDX_W-1:0]              hit_idx_reg, hit_idx_next;
    logic [IDX_W-1:0]              hit_rank_reg, hit_rank_next;
    logic                          empty_found_reg, empty_found_next;
    logic [IDX_W-1:0]              empty_idx_reg, empty_idx_next;
    logic [IDX_W-1:0]              max_idx_reg, max_idx_next;
    logic [IDX_W-1:0]              max_rank_reg, max_rank_next;
    logic [PAGE_BITS-1:0]          max_page_reg, max_page_next;
    logic [IDX_W-1:0]              chosen_reg, chosen_next;
    logic [IDX_W-1:0]              limit_reg, limit_next;
    logic                          fill_reg, fill_next;
    logic                          ev_valid_reg, ev_valid_next;
    logic [PAGE_BITS-1:0]          ev_page_reg, ev_page_next;
    logic [FRAMES-1:0]             valid_reg, valid_next;
    logic [lrup_pkg::CNT_BITS-1:0] faults_reg, faults_next;
    logic [lrup_pkg::CNT_BITS-1:0] refs_reg, refs_next;
    logic                          m_valid_reg, m_valid_next;
    logic                          m_hit_reg, m_hit_next;
    logic [IDX_W-1:0]              m_idx_reg, m_idx_next;
    logic                          m_ev_valid_reg, m_ev_valid_next;
    logic [PAGE_BITS-1:0]          m_ev_page_reg, m_ev_page_next;
    logic [lrup_pkg::CNT_BITS-1:0] m_faults_reg, m_faults_next;
    logic [lrup_pkg::CNT_BITS-1:0] m_refs_reg, m_refs_next;

    logic                 rd_en;
    logic [IDX_W-1:0]     rd_addr;
    logic [PAGE_BITS-1:0] rd_page;
    logic [IDX_W-1:0]     rd_rank;
    logic [IDX_W-1:0]     wr_addr;
    logic                 pg_we;
    logic                 rk_we;
    logic [IDX_W-1:0]     rk_wdata;

    logic [CNT_W-1:0] act_clamp;
    logic [CNT_W-1:0] lim;
    logic             issuing;
    logic             cur_valid;
    logic [IDX_W-1:0] cmp_ref;
    logic             rank_gt;
    logic             rank_lt;
    logic             s_fire;

    logic                          evicting;
    logic                          ref_fire;
    logic [lrup_pkg::CNT_BITS-1:0] refs_inc;

    lrup_frame_mem #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_mem (
        .aclk     (aclk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_page  (rd_page),
        .rd_rank  (rd_rank),
        .wr_addr  (wr_addr),
        .pg_we    (pg_we),
        .pg_wdata (page_reg),
        .rk_we    (rk_we),
        .rk_wdata (rk_wdata)
    );

    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;

    assign act_clamp = (fiu_reg == '0) ? CNT_W'(1) :
                       (fiu_reg > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) : fiu_reg;

    assign lim     = (state_reg == ST_SCAN) ? act_reg : CNT_W'(FRAMES);
    assign issuing = ((state_reg == ST_SCAN) || (state_reg == ST_UPDATE)) &&
                     (issue_cnt_reg < lim);
    assign rd_en   = issuing;
    assign rd_addr = issue_cnt_reg[IDX_W-1:0];

    assign cur_valid = valid_reg[pend_idx_reg];

    // shared rank comparator
    assign cmp_ref = (state_reg == ST_SCAN) ? max_rank_reg : limit_reg;
    assign rank_gt = rd_rank > cmp_ref;
    assign rank_lt = rd_rank < cmp_ref;

    always_comb begin
        state_next       = state_reg;
        fiu_next         = fiu_reg;
        act_next         = act_reg;
        page_next        = page_reg;
        issue_cnt_next   = issue_cnt_reg;
        pend_next        = issuing;
        pend_last_next   = issuing && (issue_cnt_reg == CNT_W'(lim - CNT_W'(1)));
        pend_idx_next    = rd_addr;
        hit_found_next   = hit_found_reg;
        hit_idx_next     = hit_idx_reg;
        hit_rank_next    = hit_rank_reg;
        empty_found_next = empty_found_reg;
        empty_idx_next   = empty_idx_reg;
        max_idx_next     = max_idx_reg;
        max_rank_next    = max_rank_reg;
        max_page_next    = max_page_reg;
        chosen_next      = chosen_reg;
        limit_next       = limit_reg;
        fill_next        = fill_reg;
        ev_valid_next    = ev_valid_reg;
        ev_page_next     = ev_page_reg;
        valid_next       = valid_reg;
        faults_next      = faults_reg;
        refs_next        = refs_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_hit_next       = m_hit_reg;
        m_idx_next       = m_idx_reg;
        m_ev_valid_next  = m_ev_valid_reg;
        m_ev_page_next   = m_ev_page_reg;
        m_faults_next    = m_faults_reg;
        m_refs_next      = m_refs_reg;
        wr_addr          = pend_idx_reg;
        pg_we            = 1'b0;
        rk_we            = 1'b0;
        rk_wdata         = '0;

        if (issuing) begin
            issue_cnt_next = issue_cnt_reg + CNT_W'(1);
        end

        if (cfg_wr_en) begin
            fiu_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    hit_found_next   = 1'b0;
                    empty_found_next = 1'b0;
                    chosen_next      = '0;
                    ev_valid_next    = 1'b0;
                    ev_page_next     = '0;
                    issue_cnt_next   = '0;
                    if (s_cmd == lrup_pkg::CMD_RESTART) begin
                        valid_next  = '0;
                        faults_next = '0;
                        refs_next   = '0;
                        state_next  = ST_FINISH;
                    end else begin
                        page_next  = s_page_number;
                        act_next   = act_clamp;
                        refs_next  = (refs_reg == lrup_pkg::CNT_MAX) ? refs_reg :
                                     refs_reg + lrup_pkg::CNT_BITS'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (pend_reg) begin
                    if (!hit_found_reg && cur_valid && (rd_page == page_reg)) begin
                        hit_found_next = 1'b1;
                        hit_idx_next   = pend_idx_reg;
                        hit_rank_next  = rd_rank;
                    end
                    if (!empty_found_reg && !cur_valid) begin
                        empty_found_next = 1'b1;
                        empty_idx_next   = pend_idx_reg;
                    end
                    if ((pend_idx_reg == '0) || rank_gt) begin
                        max_idx_next  = pend_idx_reg;
                        max_rank_next = rd_rank;
                        max_page_next = rd_page;
                    end
                    if (pend_last_reg) begin
                        state_next = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE: begin
                issue_cnt_next = '0;
                state_next     = ST_UPDATE;
                if (hit_found_reg) begin
                    chosen_next = hit_idx_reg;
                    limit_next  = hit_rank_reg;
                    fill_next   = 1'b0;
                end else begin
                    faults_next = (faults_reg == lrup_pkg::CNT_MAX) ? faults_reg :
                                  faults_reg + lrup_pkg::CNT_BITS'(1);
                    pg_we       = 1'b1;
                    if (empty_found_reg) begin
                        chosen_next               = empty_idx_reg;
                        fill_next                 = 1'b1;
                        valid_next[empty_idx_reg] = 1'b1;
                        wr_addr                   = empty_idx_reg;
                    end else begin
                        chosen_next   = max_idx_reg;
                        limit_next    = max_rank_reg;
                        fill_next     = 1'b0;
                        ev_valid_next = 1'b1;
                        ev_page_next  = max_page_reg;
                        wr_addr       = max_idx_reg;
                    end
                end
            end
            ST_UPDATE: begin
                if (pend_reg) begin
                    if (pend_idx_reg == chosen_reg) begin
                        rk_we    = 1'b1;
                        rk_wdata = '0;
                    end else if (cur_valid && (fill_reg || rank_lt)) begin
                        rk_we    = 1'b1;
                        rk_wdata = rd_rank + IDX_W'(1);
                    end
                    if (pend_last_reg) begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next    = 1'b1;
                    m_hit_next      = hit_found_reg;
                    m_idx_next      = chosen_reg;
                    m_ev_valid_next = ev_valid_reg;
                    m_ev_page_next  = ev_page_reg;
                    m_faults_next   = faults_reg;
                    m_refs_next     = refs_reg;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fiu_reg       <= CNT_W'(FRAMES);
            valid_reg     <= '0;
            faults_reg    <= '0;
            refs_reg      <= '0;
            m_valid_reg   <= 1'b0;
            pend_reg      <= 1'b0;
            pend_last_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fiu_reg       <= fiu_next;
            valid_reg     <= valid_next;
            faults_reg    <= faults_next;
            refs_reg      <= refs_next;
            m_valid_reg   <= m_valid_next;
            pend_reg      <= pend_next;
            pend_last_reg <= pend_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg         <= act_next;
        page_reg        <= page_next;
        issue_cnt_reg   <= issue_cnt_next;
        pend_idx_reg    <= pend_idx_next;
        hit_found_reg   <= hit_found_next;
        hit_idx_reg     <= hit_idx_next;
        hit_rank_reg    <= hit_rank_next;
        empty_found_reg <= empty_found_next;
        empty_idx_reg   <= empty_idx_next;
        max_idx_reg     <= max_idx_next;
        max_rank_reg    <= max_rank_next;
        max_page_reg    <= max_page_next;
        chosen_reg      <= chosen_next;
        limit_reg       <= limit_next;
        fill_reg        <= fill_next;
        ev_valid_reg    <= ev_valid_next;
        ev_page_reg     <= ev_page_next;
        m_hit_reg       <= m_hit_next;
        m_idx_reg       <= m_idx_next;
        m_ev_valid_reg  <= m_ev_valid_next;
        m_ev_page_reg   <= m_ev_page_next;
        m_faults_reg    <= m_faults_next;
        m_refs_reg      <= m_refs_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_hit             = m_hit_reg;
    assign m_frame_index     = m_idx_reg;
    assign m_evicted_valid   = m_ev_valid_reg;
    assign m_evicted_page    = m_ev_page_reg;
    assign m_fault_count     = m_faults_reg;
    assign m_reference_count = m_refs_reg;

    assign evicting = (state_reg == ST_UPDATE) && ev_valid_reg;
    assign ref_fire = s_fire && (s_cmd == lrup_pkg::CMD_REF) && (refs_reg != lrup_pkg::CNT_MAX);
    assign refs_inc = refs_reg + lrup_pkg::CNT_BITS'(1);

    `LRUP_ASSERT_NOW(a_scan_in_range, state_reg == ST_SCAN, issue_cnt_reg <= act_reg, "scan overran")
    `LRUP_ASSERT_NOW(a_evict_only_full, evicting, !(empty_found_reg || hit_found_reg), "bad evict")
    `LRUP_ASSERT_NOW(a_hit_no_evict, m_valid, !(m_hit && m_evicted_valid), "hit with eviction")
    `LRUP_ASSERT_NEXT(a_ref_count, ref_fire, refs_reg == $past(refs_inc), "count stuck")

endmodule
